// ===== sv/hfs_pkg.sv =====
// package for the hub flit switch: shared constants
// no dependencies
`timescale 1ns / 1ps
package hfs_pkg;
   localparam int unsigned HUB_BITS = 6;
   localparam int unsigned COUNT_BITS = 32;
endpackage

// ===== sv/hfs_if.sv =====
// valid/ready channel interfaces for the hub flit switch
// no dependencies
`timescale 1ns / 1ps
interface hfs_req_if #(parameter int P = 5, parameter int F = 64) ();
   logic valid;
   logic ready;
   logic [P-1:0] request_levels;
   logic [P-1:0] ack_levels;
   logic [F-1:0] flit_in [P];
   modport source (output valid, request_levels, ack_levels, flit_in, input ready);
   modport sink (input valid, request_levels, ack_levels, flit_in, output ready);
endinterface

interface hfs_rsp_if #(parameter int P = 5, parameter int F = 64) ();
   logic valid;
   logic ready;
   logic [P-1:0] ack_out_levels;
   logic [P-1:0] request_out_levels;
   logic [F-1:0] flit_out [P];
   logic [31:0] routed_total;
   logic [4:0] local_buffered;
   modport source (output valid, ack_out_levels, request_out_levels, flit_out,
      routed_total, local_buffered, input ready);
   modport sink (input valid, ack_out_levels, request_out_levels, flit_out,
      routed_total, local_buffered, output ready);
endinterface

interface hfs_csr_if ();
   logic valid;
   logic ready;
   logic [5:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== sv/hfs_lane.sv =====
// one input lane: flit fifo, alternating-bit receive, route decode of the head
// depends on hfs_pkg
`timescale 1ns / 1ps
module hfs_lane import hfs_pkg::*; #(
   parameter int P = 5, parameter int D = 4, parameter int F = 64,
   parameter int DB = 8, parameter int L = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  logic req_level,
   input  logic [F-1:0] flit_in,
   input  logic pop,
   input  logic [HUB_BITS-1:0] hub,
   output logic nonempty,
   output logic [$clog2(P)-1:0] route,
   output logic [F-1:0] head,
   output logic rx_level,
   output logic [$clog2(D+1)-1:0] fill
);
   localparam int AW = (D > 1) ? $clog2(D) : 1;
   localparam int FW = $clog2(D+1);
   localparam int RW = $clog2(P);
   localparam int DW = DB + HUB_BITS + 3;
   logic [F-1:0] store_ff [D];
   logic [AW-1:0] head_ff, tail_ff;
   logic [FW-1:0] fill_ff;
   logic rx_ff;
   logic push;
   logic [DW-1:0] dst, base, diff;

   assign nonempty = fill_ff != '0;
   assign head = store_ff[head_ff];
   assign push = (req_level != rx_ff) && (fill_ff != FW'(D));
   assign dst = DW'(head[DB-1:0]);
   assign base = DW'(L) * DW'(hub);
   assign diff = dst - base;
   assign route = (dst >= base && diff < DW'(L)) ? RW'(diff) : RW'(L);
   assign rx_level = rx_ff;
   assign fill = fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
         rx_ff <= 1'b0;
      end else if (step) begin
         if (pop) head_ff <= (head_ff == AW'(D-1)) ? '0 : head_ff + 1'b1;
         if (push) begin
            tail_ff <= (tail_ff == AW'(D-1)) ? '0 : tail_ff + 1'b1;
            rx_ff <= ~rx_ff;
         end
         fill_ff <= fill_ff + FW'(push) - FW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (step && push) store_ff[tail_ff] <= flit_in;
   end
endmodule

// ===== sv/hfs_merge.sv =====
// merging stage: round-robin reservation of outputs and forwarding
// depends on hfs_pkg
`timescale 1ns / 1ps
module hfs_merge import hfs_pkg::*; #(
   parameter int P = 5, parameter int F = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  logic [P-1:0] nonempty,
   input  logic [$clog2(P)-1:0] route [P],
   input  logic [F-1:0] head [P],
   input  logic [P-1:0] ack,
   output logic [P-1:0] pop,
   output logic [P-1:0] tx_level,
   output logic [F-1:0] held [P],
   output logic [COUNT_BITS-1:0] grants
);
   localparam int PW = $clog2(P);
   logic [P-1:0] owned_ff;
   logic [PW-1:0] owner_ff [P];
   logic [PW-1:0] rot_ff;
   logic [P-1:0] tx_ff;
   logic [F-1:0] held_ff [P];
   logic [COUNT_BITS-1:0] grants_ff;
   logic [P-1:0] own_in;
   logic [PW-1:0] owner_in [P];
   logic [P-1:0] send;
   logic [PW-1:0] send_src [P];
   logic [COUNT_BITS-1:0] g;
   int idx;
   logic found;

   always_comb begin
      own_in = owned_ff;
      owner_in = owner_ff;
      g = grants_ff;
      for (int j = 0; j < P; j++) begin
         idx = int'(rot_ff) + j;
         if (idx >= P) idx = idx - P;
         if (nonempty[idx] && !own_in[route[idx]]) begin
            own_in[route[idx]] = 1'b1;
            owner_in[route[idx]] = PW'(idx);
            g = g + 1'b1;
         end
      end
      pop = '0;
      send = '0;
      for (int o = 0; o < P; o++) send_src[o] = '0;
      for (int i = 0; i < P; i++) begin
         found = 1'b0;
         for (int o = 0; o < P; o++) begin
            if (!found && own_in[o] && owner_in[o] == PW'(i) && nonempty[i]) begin
               found = 1'b1;
               if (tx_ff[o] == ack[o]) begin
                  send[o] = 1'b1;
                  send_src[o] = PW'(i);
                  pop[i] = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owned_ff <= '0;
         rot_ff <= '0;
         tx_ff <= '0;
         grants_ff <= '0;
         for (int o = 0; o < P; o++) held_ff[o] <= '0;
      end else if (step) begin
         owned_ff <= own_in & ~send;
         rot_ff <= (rot_ff == PW'(P-1)) ? '0 : rot_ff + 1'b1;
         tx_ff <= tx_ff ^ send;
         grants_ff <= g;
         for (int o = 0; o < P; o++)
            if (send[o]) held_ff[o] <= head[send_src[o]];
      end
   end

   always_ff @(posedge clock) begin
      if (step) owner_ff <= owner_in;
   end

   assign tx_level = tx_ff;
   assign held = held_ff;
   assign grants = grants_ff;
endmodule

// ===== sv/hub_flit_switch_abp_unit.sv =====
// hub flit switch top level: lanes, merge stage and result register
// depends on hfs_pkg, hfs_if, hfs_lane, hfs_merge
`timescale 1ns / 1ps
// One request is one clock tick of a five-port input-buffered hub switch; each
// request yields one response holding the levels, last sent flits, grant count
// and local fill after that tick. A request is taken every cycle while the
// response register is empty or being read; its response appears in the next
// cycle in an output register, along with the lanes' fifo and merge stage state.
module hub_flit_switch_abp_unit import hfs_pkg::*; #(
   parameter int PORT_COUNT = 5, parameter int FIFO_DEPTH = 4,
   parameter int FLIT_BITS = 64, parameter int DEST_BITS = 8,
   parameter int LOCAL_PORTS = 4
) (
   input logic clock,
   input logic reset,
   hfs_req_if.sink req,
   hfs_rsp_if.source rsp,
   hfs_csr_if.sink csr
);
   localparam int PW = $clog2(PORT_COUNT);
   localparam int FW = $clog2(FIFO_DEPTH+1);
   logic [HUB_BITS-1:0] hub_ff;
   logic rsp_valid_ff;
   logic step;
   logic [PORT_COUNT-1:0] nonempty, pop, rx, tx;
   logic [PW-1:0] route [PORT_COUNT];
   logic [FLIT_BITS-1:0] head [PORT_COUNT];
   logic [FLIT_BITS-1:0] held [PORT_COUNT];
   logic [FW-1:0] fill [PORT_COUNT];
   logic [COUNT_BITS-1:0] grants;
   logic [4:0] local_sum;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign step = req.valid && req.ready;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) hub_ff <= '0;
      else if (csr.valid) hub_ff <= csr.data;
   end

   for (genvar k = 0; k < PORT_COUNT; k++) begin : g_lane
      hfs_lane #(.P(PORT_COUNT), .D(FIFO_DEPTH), .F(FLIT_BITS), .DB(DEST_BITS),
         .L(LOCAL_PORTS)) u_lane (
         .clock, .reset, .step, .req_level(req.request_levels[k]),
         .flit_in(req.flit_in[k]), .pop(pop[k]), .hub(hub_ff),
         .nonempty(nonempty[k]), .route(route[k]), .head(head[k]),
         .rx_level(rx[k]), .fill(fill[k]));
   end

   hfs_merge #(.P(PORT_COUNT), .F(FLIT_BITS)) u_merge (
      .clock, .reset, .step, .nonempty, .route, .head, .ack(req.ack_levels),
      .pop, .tx_level(tx), .held, .grants);

   always_comb begin
      local_sum = '0;
      for (int k = 0; k < LOCAL_PORTS; k++) local_sum = local_sum + 5'(fill[k]);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (step) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.ack_out_levels = rx;
   assign rsp.request_out_levels = tx;
   assign rsp.flit_out = held;
   assign rsp.routed_total = grants;
   assign rsp.local_buffered = local_sum;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(rsp.routed_total))
      else $error("response changed while stalled");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      (pop & ~nonempty) == '0) else $error("pop from empty fifo");
   a_grow: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(tx)) else $error("transmit level moved without request");
endmodule
